/* rtl/nls_pkg.sv */
package nls_pkg;

  localparam int unsigned NumLights = 16;
  localparam int unsigned HwSlots   = 4;
  localparam int unsigned IdxW      = $clog2(NumLights);
  localparam int unsigned SlotW     = (HwSlots > 1) ? $clog2(HwSlots) : 1;
  localparam int unsigned CntW      = $clog2(NumLights + 1);
  localparam int unsigned DistW     = 52;
  // light entry: x, y, z, color, intensity
  localparam int unsigned EntryW    = 24 * 3 + 32 + 16;

  typedef enum logic [1:0] {
    OP_QUERY = 2'd0,
    OP_SET   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SEL,
    ST_FETCH,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
    logic [31:0]        color;
    logic [15:0]        intensity;
  } entry_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic [7:0]         light_index;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic [31:0]        color;
    logic [15:0]        intensity;
  } req_t;

  typedef struct packed {
    logic [1:0]  slot_number;
    logic        slot_enabled;
    logic [7:0]  chosen_light;
    logic [31:0] chosen_color;
    logic [15:0] chosen_intensity;
    logic        lighting_enabled;
    logic        last_slot;
  } rsp_t;

  // squared difference of two Q15.8 coordinates, exact
  function automatic logic [49:0] sq_diff(logic signed [23:0] a, logic signed [23:0] b);
    logic signed [24:0] d;
    logic signed [49:0] p;
    d = 25'(signed'(a)) - 25'(signed'(b));
    p = d * d;
    return 50'(p);
  endfunction

endpackage

/* rtl/nls_if.sv */
interface nls_req_if;
  import nls_pkg::*;
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface nls_rsp_if;
  import nls_pkg::*;
  logic valid;
  logic ready;
  rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/nearest_light_slot_selector.sv */
// Set and clear give no result. Query: a scan of all light entries, then per
// enabled slot a selection pass over the candidates and a fetch, and an output
// step for every slot.
// One query in flight; the next request waits until the last result is taken.
// Reset (async, active low) clears active marks and the lighting flag;
// light RAM contents are undefined until written.
module nearest_light_slot_selector (
  input logic       clk_i,
  input logic       rst_ni,
  nls_req_if.sink   req,
  nls_rsp_if.source rsp
);
  import nls_pkg::*;

  state_e state_q, state_d;

  logic [NumLights-1:0] active_q;
  logic                 lit_q;
  logic signed [23:0]   ox_q, oy_q, oz_q;

  // candidate list in flops, read at fixed places or by loop index
  logic [IdxW-1:0]  cid_q   [NumLights];
  logic [DistW-1:0] cdist_q [NumLights];
  logic [CntW-1:0]  count_q;

  logic [CntW-1:0]  scan_q;     // read address counter
  logic             v1_q, v2_q, v3_q;
  logic [IdxW-1:0]  i1_q, i2_q, i3_q;

  logic [SlotW:0]   slot_q;
  logic [CntW-1:0]  j_q, m_q;
  logic             fetch_q;
  rsp_t             out_q;
  logic             out_v_q;

  entry_t rd_entry;
  logic [DistW-1:0] dist_sum;
  logic [IdxW-1:0] raddr;
  logic we;
  logic acc;
  logic [CntW-1:0] slots;

  assign acc   = req.valid && req.ready;
  assign req.ready = (state_q == ST_IDLE) && !out_v_q;
  assign we = acc && (op_e'(req.payload.operation) == OP_SET) &&
              (req.payload.light_index < 8'(NumLights));
  assign slots = (count_q < CntW'(HwSlots)) ? count_q : CntW'(HwSlots);

  always_comb begin
    raddr = scan_q[IdxW-1:0];
    if (state_q == ST_FETCH || state_q == ST_OUT) begin
      raddr = cid_q[slot_q[SlotW-1:0]];
    end
  end

  nls_ram #(.Width(EntryW), .Depth(NumLights)) u_ram (
    .clk_i,
    .we_i    (we),
    .waddr_i (req.payload.light_index[IdxW-1:0]),
    .wdata_i ({req.payload.pos_x, req.payload.pos_y, req.payload.pos_z,
               req.payload.color, req.payload.intensity}),
    .raddr_i (raddr),
    .rdata_o (rd_entry)
  );

  nls_dist u_dist (
    .clk_i,
    .entry_i (rd_entry),
    .obj_x_i (ox_q),
    .obj_y_i (oy_q),
    .obj_z_i (oz_q),
    .dist_o  (dist_sum)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (acc && op_e'(req.payload.operation) == OP_QUERY) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_q == CntW'(NumLights) && !v1_q && !v2_q && !v3_q) begin
          state_d = (slots == '0) ? ST_OUT : ST_SEL;
        end
      end
      ST_SEL: begin
        if (j_q >= count_q) state_d = ST_FETCH;
      end
      ST_FETCH: begin
        if (fetch_q) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_v_q || rsp.ready) begin
          if (slot_q == (SlotW+1)'(HwSlots - 1)) state_d = ST_IDLE;
          else if ((SlotW+1)'(slots) > slot_q + 1'b1) state_d = ST_SEL;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  // active marks and lighting flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
      lit_q    <= 1'b0;
    end else begin
      if (we) active_q[req.payload.light_index[IdxW-1:0]] <= 1'b1;
      if (acc && op_e'(req.payload.operation) == OP_CLEAR) begin
        active_q <= '0;
        lit_q    <= 1'b0;
      end
      if (state_q == ST_SCAN && state_d != ST_SCAN) lit_q <= (slots != '0);
    end
  end

  // scan pipeline: read, distance stage 1, stage 2
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= '0;
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0;
      count_q <= '0;
    end else begin
      v1_q <= 1'b0;
      if (state_q == ST_IDLE) begin
        scan_q  <= '0;
        count_q <= '0;
      end else if (state_q == ST_SCAN && scan_q != CntW'(NumLights)) begin
        scan_q <= scan_q + 1'b1;
        v1_q   <= active_q[scan_q[IdxW-1:0]];
      end
      v2_q <= v1_q && (rd_entry.intensity != '0);
      v3_q <= v2_q;
      if (v3_q) count_q <= count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    i1_q <= scan_q[IdxW-1:0];
    i2_q <= i1_q;
    i3_q <= i2_q;
    if (acc) begin
      ox_q <= req.payload.pos_x;
      oy_q <= req.payload.pos_y;
      oz_q <= req.payload.pos_z;
    end
  end

  // selection: one compare per cycle, swap at pass end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= '0;
      j_q     <= '0;
      m_q     <= '0;
      fetch_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (state_q == ST_OUT && (!out_v_q || rsp.ready)) out_v_q <= 1'b1;
      else if (rsp.ready) out_v_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          slot_q <= '0;
          j_q    <= CntW'(1);
          m_q    <= '0;
        end
        ST_SEL: begin
          if (j_q < count_q) begin
            if (cdist_q[j_q[IdxW-1:0]] < cdist_q[m_q[IdxW-1:0]]) m_q <= j_q;
            j_q <= j_q + 1'b1;
          end
          fetch_q <= 1'b0;
        end
        ST_FETCH: fetch_q <= 1'b1;
        ST_OUT: begin
          if (!out_v_q || rsp.ready) begin
            slot_q  <= slot_q + 1'b1;
            m_q     <= CntW'(slot_q) + 1'b1;
            j_q     <= CntW'(slot_q) + 2'd2;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (v3_q) begin
      cid_q[count_q[IdxW-1:0]]   <= i3_q;
      cdist_q[count_q[IdxW-1:0]] <= dist_sum;
    end
    if (state_q == ST_SEL && j_q >= count_q && m_q != CntW'(slot_q)) begin
      cid_q[slot_q[SlotW-1:0]]   <= cid_q[m_q[IdxW-1:0]];
      cdist_q[slot_q[SlotW-1:0]] <= cdist_q[m_q[IdxW-1:0]];
      cid_q[m_q[IdxW-1:0]]       <= cid_q[slot_q[SlotW-1:0]];
      cdist_q[m_q[IdxW-1:0]]     <= cdist_q[slot_q[SlotW-1:0]];
    end
    if (state_q == ST_OUT && (!out_v_q || rsp.ready)) begin
      out_q.slot_number      <= 2'(slot_q);
      out_q.last_slot        <= (slot_q == (SlotW+1)'(HwSlots - 1));
      out_q.lighting_enabled <= (slots != '0);
      if ((SlotW+1)'(slots) > slot_q) begin
        out_q.slot_enabled     <= 1'b1;
        out_q.chosen_light     <= 8'(cid_q[slot_q[SlotW-1:0]]);
        out_q.chosen_color     <= rd_entry.color;
        out_q.chosen_intensity <= rd_entry.intensity;
      end else begin
        out_q.slot_enabled     <= 1'b0;
        out_q.chosen_light     <= '0;
        out_q.chosen_color     <= '0;
        out_q.chosen_intensity <= '0;
      end
    end
  end

  assign rsp.valid   = out_v_q;
  assign rsp.payload = out_q;

  logic unused;
  assign unused = lit_q;
endmodule

/* rtl/nls_ram.sv */
module nls_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* rtl/nls_dist.sv */
// distance unit: two register stages from entry data to squared distance
module nls_dist (
  input  logic                   clk_i,
  input  nls_pkg::entry_t        entry_i,
  input  logic signed [23:0]     obj_x_i,
  input  logic signed [23:0]     obj_y_i,
  input  logic signed [23:0]     obj_z_i,
  output logic [nls_pkg::DistW-1:0] dist_o
);
  import nls_pkg::*;

  logic [49:0] sx_q, sy_q, sz_q;

  always_ff @(posedge clk_i) begin
    sx_q   <= sq_diff(entry_i.x, obj_x_i);
    sy_q   <= sq_diff(entry_i.y, obj_y_i);
    sz_q   <= sq_diff(entry_i.z, obj_z_i);
    dist_o <= DistW'(sx_q) + DistW'(sy_q) + DistW'(sz_q);
  end
endmodule

/* rtl/nls_checker.sv */
module nls_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          req_valid_i,
  input logic          req_ready_i,
  input logic          rsp_valid_i,
  input logic          rsp_ready_i,
  input nls_pkg::rsp_t rsp_payload_i
);
  import nls_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_payload_i))
    else $error("response dropped while stalled");

  a_dis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_payload_i.slot_enabled |->
      rsp_payload_i.chosen_light == '0 && rsp_payload_i.chosen_color == '0)
    else $error("disabled slot carries data");

  a_lit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_payload_i.slot_enabled |-> rsp_payload_i.lighting_enabled)
    else $error("slot enabled without lighting");

  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> rsp_payload_i.last_slot ==
      (rsp_payload_i.slot_number == 2'(HwSlots - 1)))
    else $error("last slot flag wrong");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> !req_ready_i)
    else $error("request taken during response");

  logic unused;
  assign unused = req_valid_i;
endmodule

bind nearest_light_slot_selector nls_checker u_nls_checker (
  .clk_i,
  .rst_ni,
  .req_valid_i   (req.valid),
  .req_ready_i   (req.ready),
  .rsp_valid_i   (rsp.valid),
  .rsp_ready_i   (rsp.ready),
  .rsp_payload_i (rsp.payload)
);
